>>> rtl/ptt_pkg.sv
// Package for the PDO transmit trigger: codes, field widths and the
// state and configuration records shared by the decision logic and top level.
// No dependencies.
`default_nettype none

package ptt_pkg;

  localparam int TIMER_W   = 20;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  // transmission types with special handling
  localparam logic [7:0] TT_ACYCLIC   = 8'h00;
  localparam logic [7:0] TT_CYCLIC_HI = 8'hf0;
  localparam logic [7:0] TT_RTR_SYNC  = 8'hfc;
  localparam logic [7:0] TT_RTR_ONLY  = 8'hfd;
  localparam logic [7:0] TT_EVENT_LO  = 8'hfe;
  localparam logic [7:0] TT_EVENT_HI  = 8'hff;

  localparam logic [7:0] SYNC_CNT_MAX = 8'd240;

  typedef enum logic [1:0] {
    OP_EVENT  = 2'd0,
    OP_SYNC   = 2'd1,
    OP_REMOTE = 2'd2,
    OP_TICK   = 2'd3
  } ptt_op_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_SEND      = 3'd1,
    ACT_SAMPLE    = 3'd2,
    ACT_SEND_BUF  = 3'd3,
    ACT_INHIBITED = 3'd4,
    ACT_BAD_CNT   = 3'd5
  } ptt_action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PDO_ENABLED  = 3'd0,
    REG_RTR_DISABLED = 3'd1,
    REG_TRANS_TYPE   = 3'd2,
    REG_INHIBIT_TIME = 3'd3,
    REG_EVENT_TIME   = 3'd4,
    REG_SYNC_START   = 3'd5
  } ptt_reg_t;

  typedef struct packed {
    logic        pdo_enabled;
    logic        rtr_disabled;
    logic [7:0]  trans_type;
    logic [15:0] inhibit_time;
    logic [15:0] event_time;
    logic [7:0]  sync_start;
  } ptt_cfg_t;

  typedef struct packed {
    logic               event_pending;
    logic [7:0]         sync_wait_value;
    logic [7:0]         sync_count;
    logic [15:0]        inhibit_left;
    logic [TIMER_W-1:0] event_timer_left;
    logic               buffer_valid;
  } ptt_state_t;

endpackage

`default_nettype wire

>>> rtl/pdo_transmit_trigger.sv
// Top level of the PDO transmit trigger: input register, configuration
// registers, trigger state, timer load and result register. Uses ptt_pkg, ptt_decide.
`default_nettype none

// Usage:
//   in_*   : one transfer per bus item; in_tdata = {sync_counter, opcode}
//            (opcode in bits 1:0, sync_counter in bits 9:2). Opcodes are an
//            application event, a SYNC, a remote request or a 100 us tick.
//   out_*  : exactly one transfer per input transfer, in order; out_tdata
//            bits 2:0 carry the action code.
//   cfg_*  : register write when cfg_we is high; cfg_idx picks the register
//            (0 enable, 1 RTR disable, 2 type, 3 inhibit time, 4 event time,
//            5 SYNC start); indexes 6 and 7 are ignored. Write only while no
//            transfer is in flight.
//   Path: an item passes the input register, then the result register.
//   Throughput: one item per cycle while out_tready stays high; the
//   decision is one pass of logic between the two registers.
//   Stall: when out_tready is low the result register holds, the input
//   register keeps one more item, and in_tready drops only when both are full.
//   Reset: synchronous active-low rst_n clears both valid flags, loads the
//   register reset values (disabled, RTR refused, type 255) and clears the
//   trigger state; the event timer starts stopped.
module pdo_transmit_trigger
  import ptt_pkg::*;
#(
  parameter int TICKS_PER_MS = 10
) (
  input  wire                   clk,
  input  wire                   rst_n,
  // [1:0] opcode, [9:2] sync_counter, [15:10] zero
  input  wire [IN_DATA_W-1:0]   in_tdata,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  // [2:0] action, [7:3] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_idx,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int MUL_W  = 16 + $clog2(TICKS_PER_MS + 1);
  localparam int PROD_W = (MUL_W > TIMER_W) ? MUL_W : TIMER_W + 1;

  logic        in_valid_r;
  ptt_op_t     in_op_r;
  logic [7:0]  in_cnt_r;
  logic        out_valid_r;
  ptt_action_t out_action_r;

  ptt_cfg_t    cfg_r, cfg_nxt;
  ptt_state_t  st_r, st_nxt, st_step;
  ptt_action_t step_action;

  logic               advance;
  logic               arm_active;
  logic [PROD_W-1:0]  timer_prod;
  logic [TIMER_W-1:0] arm_load;

  // move the held item into the result register when that slot frees up
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - 3)'(0), out_action_r};

  // configuration as it stands after this cycle's write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_PDO_ENABLED:  cfg_nxt.pdo_enabled  = cfg_wdata[0];
        REG_RTR_DISABLED: cfg_nxt.rtr_disabled = cfg_wdata[0];
        REG_TRANS_TYPE:   cfg_nxt.trans_type   = cfg_wdata[7:0];
        REG_INHIBIT_TIME: cfg_nxt.inhibit_time = cfg_wdata;
        REG_EVENT_TIME:   cfg_nxt.event_time   = cfg_wdata;
        REG_SYNC_START:   cfg_nxt.sync_start   = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // event timer reload: ms period scaled to ticks, saturated to the counter
  assign timer_prod = PROD_W'(cfg_nxt.event_time) * PROD_W'(TICKS_PER_MS);
  assign arm_active = cfg_nxt.pdo_enabled && cfg_nxt.event_time != 16'd0 &&
                      (cfg_nxt.trans_type == TT_ACYCLIC ||
                       cfg_nxt.trans_type >= TT_EVENT_LO);
  assign arm_load   = !arm_active ? '0 :
                      (timer_prod > PROD_W'(TIMER_MAX)) ? TIMER_MAX :
                      timer_prod[TIMER_W-1:0];

  ptt_decide u_decide (
    .cfg      (cfg_r),
    .st_cur   (st_r),
    .op       (in_op_r),
    .sync_cnt (in_cnt_r),
    .arm_load (arm_load),
    .action   (step_action),
    .st_nxt   (st_step)
  );

  // state update: register writes must arrive only while idle; the block does
  // not enforce it, and a write drops the state step of an advancing item
  always_comb begin
    st_nxt = st_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_PDO_ENABLED: begin
          if (cfg_wdata[0] != cfg_r.pdo_enabled) begin
            if (cfg_wdata[0]) begin
              st_nxt.event_pending   = 1'b0;
              st_nxt.sync_wait_value = cfg_r.sync_start;
              st_nxt.sync_count      = 8'd0;
              st_nxt.inhibit_left    = 16'd0;
            end
            st_nxt.buffer_valid     = 1'b0;
            st_nxt.event_timer_left = arm_load;
          end
        end
        REG_TRANS_TYPE: begin
          if (cfg_wdata[7:0] != cfg_r.trans_type) begin
            st_nxt.event_pending    = 1'b0;
            st_nxt.buffer_valid     = 1'b0;
            st_nxt.event_timer_left = arm_load;
          end
        end
        REG_EVENT_TIME: begin
          if (cfg_wdata != cfg_r.event_time) begin
            st_nxt.event_timer_left = arm_load;
          end
        end
        default: ;
      endcase
    end else if (advance) begin
      st_nxt = st_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r       <= '{pdo_enabled: 1'b0, rtr_disabled: 1'b1, trans_type: 8'hff,
                       inhibit_time: 16'd0, event_time: 16'd0, sync_start: 8'd0};
      st_r        <= '0;
    end else begin
      cfg_r <= cfg_nxt;
      st_r  <= st_nxt;
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r  <= ptt_op_t'(in_tdata[1:0]);
      in_cnt_r <= in_tdata[9:2];
    end
    if (advance) begin
      out_action_r <= step_action;
    end
  end

  // the event timer only runs for the types that use it
  a_timer_types: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.event_timer_left != '0 |->
      cfg_r.pdo_enabled && (cfg_r.trans_type == TT_ACYCLIC ||
                            cfg_r.trans_type >= TT_EVENT_LO))
    else $error("event timer running for a type without one");

  // an item leaving the input register always lands in the result register
  a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced item lost");

  // a SYNC with an out-of-range counter reports a bad counter
  a_bad_counter: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_op_r == OP_SYNC && in_cnt_r > SYNC_CNT_MAX |=>
      out_action_r == ACT_BAD_CNT)
    else $error("bad SYNC counter not flagged");

  // a bad counter never touches the trigger state
  a_bad_counter_hold: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !cfg_we && in_op_r == OP_SYNC && in_cnt_r > SYNC_CNT_MAX |=>
      $stable(st_r))
    else $error("bad SYNC counter changed state");

endmodule

`default_nettype wire

>>> rtl/ptt_decide.sv
// Single-pass decision logic: one input item against the current state and
// configuration gives one action and the next state. Uses ptt_pkg.
`default_nettype none

module ptt_decide
  import ptt_pkg::*;
(
  input  wire ptt_cfg_t           cfg,
  input  wire ptt_state_t         st_cur,
  input  wire ptt_op_t            op,
  input  wire [7:0]               sync_cnt,
  input  wire [TIMER_W-1:0]       arm_load,
  output ptt_action_t             action,
  output ptt_state_t              st_nxt
);

  always_comb begin
    logic        ev;
    logic        is_event_tt;
    logic [7:0]  cnt_inc;

    st_nxt      = st_cur;
    action      = ACT_NONE;
    ev          = 1'b0;
    is_event_tt = (cfg.trans_type == TT_EVENT_LO) || (cfg.trans_type == TT_EVENT_HI);
    cnt_inc     = st_cur.sync_count + 8'd1;

    case (op)
      OP_EVENT: ev = 1'b1;
      OP_SYNC: begin
        if (sync_cnt > SYNC_CNT_MAX) begin
          action = ACT_BAD_CNT;
        end else if (!cfg.pdo_enabled) begin
          action = ACT_NONE;
        end else if (cfg.trans_type > TT_CYCLIC_HI && cfg.trans_type != TT_RTR_SYNC) begin
          action = ACT_NONE;
        end else if (st_cur.sync_wait_value != 8'd0 && sync_cnt != 8'd0 &&
                     st_cur.sync_wait_value != sync_cnt) begin
          // still waiting for the start counter value
          action = ACT_NONE;
        end else begin
          if (st_cur.sync_wait_value != 8'd0 && sync_cnt != 8'd0) begin
            st_nxt.sync_wait_value = 8'd0;
            st_nxt.sync_count      = 8'd0;
            cnt_inc                = 8'd1;
          end
          if (cfg.trans_type == TT_ACYCLIC) begin
            if (st_cur.event_pending) begin
              st_nxt.event_pending = 1'b0;
              action               = ACT_SEND;
            end
          end else if (cfg.trans_type <= TT_CYCLIC_HI) begin
            if (cnt_inc < cfg.trans_type) begin
              st_nxt.sync_count = cnt_inc;
            end else begin
              st_nxt.sync_count = 8'd0;
              action            = ACT_SEND;
            end
          end else begin
            st_nxt.buffer_valid = 1'b1;
            action              = ACT_SAMPLE;
          end
        end
      end
      OP_REMOTE: begin
        if (cfg.pdo_enabled && !cfg.rtr_disabled) begin
          if (cfg.trans_type == TT_RTR_SYNC && st_cur.buffer_valid) begin
            action = ACT_SEND_BUF;
          end else if (cfg.trans_type == TT_RTR_SYNC || cfg.trans_type == TT_RTR_ONLY) begin
            st_nxt.buffer_valid = 1'b1;
            action              = ACT_SEND;
          end
        end
      end
      default: begin
        if (st_cur.inhibit_left != 16'd0) begin
          st_nxt.inhibit_left = st_cur.inhibit_left - 16'd1;
        end
        if (st_cur.event_timer_left != '0) begin
          st_nxt.event_timer_left = st_cur.event_timer_left - TIMER_W'(1);
          ev = (st_cur.event_timer_left == TIMER_W'(1));
        end
      end
    endcase

    // application event, or one raised by the event timer running out
    if (ev && cfg.pdo_enabled) begin
      if (cfg.trans_type == TT_ACYCLIC) begin
        st_nxt.event_pending    = 1'b1;
        st_nxt.event_timer_left = arm_load;
      end else if (cfg.trans_type == TT_RTR_ONLY) begin
        st_nxt.buffer_valid     = 1'b1;
        st_nxt.event_timer_left = arm_load;
        action                  = ACT_SAMPLE;
      end else if (is_event_tt) begin
        if (cfg.inhibit_time != 16'd0 && st_nxt.inhibit_left != 16'd0) begin
          action = ACT_INHIBITED;
        end else begin
          if (cfg.inhibit_time != 16'd0) begin
            st_nxt.inhibit_left = cfg.inhibit_time;
          end
          st_nxt.event_timer_left = arm_load;
          action                  = ACT_SEND;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for pdo_transmit_trigger: stream stimulus, register writes between
// phases and a scoreboard class that predicts one action code per input transfer.
// Depends on ptt_pkg and the pdo_transmit_trigger RTL.
`timescale 1ns / 1ps

import ptt_pkg::*;

// Trigger predictor: holds its own copy of the registers and trigger state and
// queues the expected action for every accepted input transfer.
class trigger_scoreboard #(int TICKS_PER_MS = 10);
  bit                 pdo_enabled;
  bit                 rtr_disabled;
  bit [7:0]           trans_type;
  bit [15:0]          inhibit_time;
  bit [15:0]          event_time;
  bit [7:0]           sync_start;

  bit                 event_pending;
  bit [7:0]           sync_wait_value;
  bit [7:0]           sync_count;
  bit [15:0]          inhibit_left;
  bit [TIMER_W-1:0]   event_timer_left;
  bit                 buffer_valid;

  ptt_action_t        action_q[$];
  int                 mismatches;

  function new();
    pdo_enabled      = 1'b0;
    rtr_disabled     = 1'b1;
    trans_type       = TT_EVENT_HI;
    inhibit_time     = '0;
    event_time       = '0;
    sync_start       = '0;
    event_pending    = 1'b0;
    sync_wait_value  = '0;
    sync_count       = '0;
    inhibit_left     = '0;
    event_timer_left = '0;
    buffer_valid     = 1'b0;
    mismatches       = 0;
  endfunction

  function int pending();
    return action_q.size();
  endfunction

  function void arm_timer();
    bit          active;
    int unsigned load;
    active = pdo_enabled && (trans_type == TT_ACYCLIC || trans_type >= TT_EVENT_LO) &&
             event_time != 0;
    load = event_time * TICKS_PER_MS;
    if (load > TIMER_MAX) load = TIMER_MAX;
    event_timer_left = active ? load[TIMER_W-1:0] : '0;
  endfunction

  function ptt_action_t app_trigger();
    if (!pdo_enabled) return ACT_NONE;
    if (trans_type == TT_ACYCLIC) begin
      event_pending = 1'b1;
      arm_timer();
      return ACT_NONE;
    end
    if (trans_type == TT_RTR_ONLY) begin
      buffer_valid = 1'b1;
      arm_timer();
      return ACT_SAMPLE;
    end
    if (trans_type == TT_EVENT_LO || trans_type == TT_EVENT_HI) begin
      if (inhibit_time != 0) begin
        // still inside the inhibit window: refuse and leave the timer as it is
        if (inhibit_left != 0) return ACT_INHIBITED;
        inhibit_left = inhibit_time;
      end
      arm_timer();
      return ACT_SEND;
    end
    return ACT_NONE;
  endfunction

  function ptt_action_t sync_trigger(bit [7:0] cnt);
    if (cnt > SYNC_CNT_MAX) return ACT_BAD_CNT;
    if (!pdo_enabled) return ACT_NONE;
    if (trans_type > TT_CYCLIC_HI && trans_type != TT_RTR_SYNC) return ACT_NONE;
    // hold counting until the SYNC counter reaches the start value
    if (sync_wait_value != 0 && cnt != 0) begin
      if (sync_wait_value != cnt) return ACT_NONE;
      sync_wait_value = '0;
      sync_count      = '0;
    end
    if (trans_type == TT_ACYCLIC) begin
      if (!event_pending) return ACT_NONE;
      event_pending = 1'b0;
    end else if (trans_type <= TT_CYCLIC_HI) begin
      sync_count = sync_count + 8'd1;
      if (sync_count < trans_type) return ACT_NONE;
      sync_count = '0;
    end
    if (trans_type <= TT_CYCLIC_HI) return ACT_SEND;
    buffer_valid = 1'b1;
    return ACT_SAMPLE;
  endfunction

  function ptt_action_t remote_trigger();
    if (!pdo_enabled || rtr_disabled) return ACT_NONE;
    if (trans_type == TT_RTR_SYNC && buffer_valid) return ACT_SEND_BUF;
    if (trans_type == TT_RTR_SYNC || trans_type == TT_RTR_ONLY) begin
      buffer_valid = 1'b1;
      return ACT_SEND;
    end
    return ACT_NONE;
  endfunction

  function ptt_action_t tick_trigger();
    if (inhibit_left != 0) inhibit_left = inhibit_left - 16'd1;
    if (event_timer_left != 0) begin
      event_timer_left = event_timer_left - 1'b1;
      if (event_timer_left == 0) return app_trigger();
    end
    return ACT_NONE;
  endfunction

  function void write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_PDO_ENABLED: begin
        if (val[0] != pdo_enabled) begin
          pdo_enabled = val[0];
          if (val[0]) begin
            event_pending   = 1'b0;
            sync_wait_value = sync_start;
            sync_count      = '0;
            inhibit_left    = '0;
          end
          buffer_valid = 1'b0;
          arm_timer();
        end
      end
      REG_RTR_DISABLED: rtr_disabled = val[0];
      REG_TRANS_TYPE: begin
        if (val[7:0] != trans_type) begin
          trans_type    = val[7:0];
          event_pending = 1'b0;
          buffer_valid  = 1'b0;
          arm_timer();
        end
      end
      REG_INHIBIT_TIME: inhibit_time = val;
      REG_EVENT_TIME: begin
        if (val != event_time) begin
          event_time = val;
          arm_timer();
        end
      end
      REG_SYNC_START: sync_start = val[7:0];
      default: ;
    endcase
  endfunction

  // Predict the action for one accepted input transfer.
  function void note_input(logic [IN_DATA_W-1:0] data);
    ptt_op_t     op;
    ptt_action_t act;
    op = ptt_op_t'(data[1:0]);
    case (op)
      OP_EVENT:  act = app_trigger();
      OP_SYNC:   act = sync_trigger(data[9:2]);
      OP_REMOTE: act = remote_trigger();
      default:   act = tick_trigger();
    endcase
    action_q.push_back(act);
  endfunction

  // Compare one accepted result transfer with the oldest prediction.
  function void check_result(logic [OUT_DATA_W-1:0] data);
    ptt_action_t want;
    if (action_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: action %0d", data[2:0]);
      return;
    end
    want = action_q.pop_front();
    if (data[2:0] !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("action mismatch: expected %0d (%s), got %0d", want, want.name(), data[2:0]);
    end
  endfunction
endclass

module testbench;
  localparam int TICKS_PER_MS   = 10;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PHASES  = 16;
  localparam int PHASE_ITEMS    = 90;

  // indexes beyond the register file; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int       sender_idle_pct;
  int       recv_stall_pct;
  int       quiet_cycles;
  bit [7:0] cur_sync_start;

  trigger_scoreboard #(TICKS_PER_MS) sb;

  pdo_transmit_trigger #(
    .TICKS_PER_MS(TICKS_PER_MS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Monitor: note input transfers and check result transfers at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // Receiver: stall the result channel at the rate of the current phase.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin sender_idle_pct = 56; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  recv_stall_pct = 56; end
      default:       begin sender_idle_pct = 21; recv_stall_pct = 21; end
    endcase
  endtask

  // Offer one item; idle with noise on tdata first, then hold until the transfer.
  task automatic send_item(ptt_op_t op, logic [7:0] cnt);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_DATA_W'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, cnt, op};
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid, wait for every predicted result, then let the pipeline empty.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_config(idx, val);
  endtask

  // Write a full setting; optionally pulse the enable so the trigger state restarts.
  // Unused upper bits of the narrow registers carry junk that must be ignored.
  task automatic apply_setting(bit en, bit rtr_off, bit [7:0] tt, bit [15:0] inh,
                               bit [15:0] evt, bit [7:0] start, bit restart);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_SYNC_START, {junk[15:8], start});
    write_reg(REG_INHIBIT_TIME, inh);
    write_reg(REG_EVENT_TIME, evt);
    write_reg(REG_RTR_DISABLED, {junk[15:1], rtr_off});
    write_reg(REG_TRANS_TYPE, {junk[7:0], tt});
    if (restart) write_reg(REG_PDO_ENABLED, {junk[14:0], 1'b0});
    write_reg(REG_PDO_ENABLED, {junk[15:1], en});
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, junk);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_sync_start = start;
  endtask

  // Pick a random setting, leaning toward small times so timers run out often.
  task automatic random_setting(int phase);
    bit [7:0]  tt;
    bit [15:0] inh;
    bit [15:0] evt;
    bit [7:0]  start;
    case ($urandom_range(0, 9))
      0:       tt = TT_ACYCLIC;
      1:       tt = 8'($urandom_range(1, 4));
      2:       tt = $urandom_range(0, 1) ? TT_CYCLIC_HI : 8'($urandom_range(5, 239));
      3:       tt = 8'($urandom_range(241, 251));
      4:       tt = TT_RTR_SYNC;
      5:       tt = TT_RTR_ONLY;
      6, 7:    tt = TT_EVENT_LO;
      default: tt = TT_EVENT_HI;
    endcase
    case ($urandom_range(0, 7))
      0, 1:    inh = '0;
      2:       inh = 16'hffff;
      3:       inh = 16'($urandom);
      default: inh = 16'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 7))
      0, 1:    evt = '0;
      2:       evt = 16'hffff;
      default: evt = 16'($urandom_range(1, 3));
    endcase
    case ($urandom_range(0, 4))
      0, 1:    start = '0;
      2:       start = SYNC_CNT_MAX;
      default: start = 8'($urandom_range(1, 10));
    endcase
    // two phases at the extremes of every register but the enable, which stays on
    if (phase == 0)
      apply_setting(1'b1, 1'b0, TT_ACYCLIC, 16'h0000, 16'h0000, 8'd0, 1'b1);
    else if (phase == 1)
      apply_setting(1'b1, 1'b1, TT_EVENT_HI, 16'hffff, 16'hffff, SYNC_CNT_MAX, 1'b1);
    else
      apply_setting($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)), tt, inh, evt,
                    start, 1'($urandom_range(0, 1)));
  endtask

  task automatic random_item();
    ptt_op_t  op;
    bit [7:0] cnt;
    case ($urandom_range(0, 9))
      0, 1, 2: op = OP_EVENT;
      3, 4:    op = OP_SYNC;
      5:       op = OP_REMOTE;
      default: op = OP_TICK;
    endcase
    // SYNC counters: absent, the start value, in range, or out of range
    case ($urandom_range(0, 9))
      0, 1, 2, 3: cnt = '0;
      4, 5:       cnt = cur_sync_start;
      6, 7, 8:    cnt = 8'($urandom_range(1, 240));
      default:    cnt = 8'($urandom_range(241, 255));
    endcase
    send_item(op, cnt);
  endtask

  initial begin
    sb              = new();
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    out_tready      = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    quiet_cycles    = 0;
    cur_sync_start  = '0;
    set_idling(IDLE_NONE);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset setting, PDO disabled; bad counters still flagged.
    send_item(OP_SYNC, 8'd241);
    send_item(OP_SYNC, 8'd255);
    send_item(OP_EVENT, 8'd0);
    send_item(OP_REMOTE, 8'd0);
    send_item(OP_TICK, 8'd0);
    settle();

    // Event-driven with inhibit: send, inhibited, send after the window, timer expiry.
    apply_setting(1'b1, 1'b0, TT_EVENT_LO, 16'd2, 16'd1, 8'd0, 1'b1);
    send_item(OP_EVENT, 8'd0);
    send_item(OP_EVENT, 8'd0);
    repeat (2) send_item(OP_TICK, 8'd0);
    send_item(OP_EVENT, 8'd0);
    repeat (10) send_item(OP_TICK, 8'd0);
    settle();

    // Acyclic with a SYNC start value: wrong counter ignored, matching one sends.
    apply_setting(1'b1, 1'b0, TT_ACYCLIC, 16'd0, 16'd0, 8'd3, 1'b1);
    send_item(OP_EVENT, 8'd0);
    send_item(OP_SYNC, 8'd5);
    send_item(OP_SYNC, 8'd3);
    settle();

    // RTR-synchronous: remote without buffer, SYNC sample, remote sends buffer.
    apply_setting(1'b1, 1'b0, TT_RTR_SYNC, 16'd0, 16'd0, 8'd0, 1'b0);
    send_item(OP_REMOTE, 8'd0);
    send_item(OP_SYNC, 8'd0);
    send_item(OP_REMOTE, 8'd0);
    settle();

    // RTR-only: event samples, remote sends.
    apply_setting(1'b1, 1'b0, TT_RTR_ONLY, 16'd0, 16'd0, 8'd0, 1'b0);
    send_item(OP_EVENT, 8'd0);
    send_item(OP_REMOTE, 8'd0);
    settle();

    // Random phases: rotate the idling pattern, change the setting between phases.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_setting(phase);
      set_idling(idle_mode_t'(phase % 4));
      repeat (PHASE_ITEMS) random_item();
      settle();
    end

    if (sb.pending() != 0) $display("%0d predicted results never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
